// ----- hw/rtl/ihe_pkg.sv -----
// Shared types and constants for the IEEE-488 handshake engine.
// No dependencies; every other file of the engine uses this package.
`default_nettype none

package ihe_pkg;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_RECV = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] EOS_CRLF     = 2'd0;
    localparam logic [1:0] EOS_CR       = 2'd1;
    localparam logic [1:0] EOS_LF       = 2'd2;
    localparam logic [1:0] EOS_EOI_ONLY = 2'd3;

    localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_EOS_MODE      = 2'd1;

    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] WAIT_FOREVER  = 8'hFF;
    localparam logic [7:0] DATA_FLOAT    = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       use_eoi;
        logic       until_eoi;
        logic [7:0] bus_data;
        logic       line_dav;
        logic       line_nrfd;
        logic       line_ndac;
        logic       line_eoi;
        logic       line_atn;
        logic       tick;
    } in_t;

    typedef struct packed {
        logic [7:0] drive_data;
        logic       drive_dav_low;
        logic       drive_eoi_low;
        logic       drive_nrfd_low;
        logic       drive_ndac_low;
        logic       talker_mode;
        logic       busy_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
        logic       rx_eoi;
        logic       rx_atn;
        logic       msg_end;
    } out_t;

    // classified request as it travels from front to back
    typedef struct packed {
        logic       cmd_send;
        logic       cmd_recv;
        logic [7:0] tx_byte;
        logic       tx_eoi;
        logic       eoi_only;
        logic [7:0] rx_byte;
        logic       dav_high;
        logic       nrfd_high;
        logic       ndac_high;
        logic       eoi_asserted;
        logic       atn_asserted;
        logic       tick;
    } item_t;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ihe_queue.sv -----
// Short register queue between the front and back of the handshake engine.
// Depends on ihe_pkg for the request type.
`default_nettype none

module ihe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ihe_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output ihe_pkg::item_t      head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    ihe_pkg::item_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ihe_front.sv -----
// Front end: accepts bus samples and commands and classifies them into requests.
// Depends on ihe_pkg; feeds ihe_queue.
`default_nettype none

module ihe_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ihe_pkg::in_t   s_data,
    input  wire logic           queue_full,
    output logic                push,
    output ihe_pkg::item_t      push_item
);

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        push_item.cmd_send     = (s_data.opcode == ihe_pkg::OP_SEND);
        push_item.cmd_recv     = (s_data.opcode == ihe_pkg::OP_RECV);
        push_item.tx_byte      = s_data.tx_byte;
        push_item.tx_eoi       = s_data.use_eoi && s_data.tx_last;
        push_item.eoi_only     = s_data.until_eoi;
        push_item.rx_byte      = ~s_data.bus_data;
        push_item.dav_high     = s_data.line_dav;
        push_item.nrfd_high    = s_data.line_nrfd;
        push_item.ndac_high    = s_data.line_ndac;
        push_item.eoi_asserted = !s_data.line_eoi;
        push_item.atn_asserted = !s_data.line_atn;
        push_item.tick         = s_data.tick;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ihe_back.sv -----
// Back end: handshake state machine, wait timer, terminator check, result register.
// Depends on ihe_pkg; consumes requests from ihe_queue.
`default_nettype none

module ihe_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ihe_pkg::cfg_wr_t cfg_wr,
    input  wire logic             head_valid,
    input  wire ihe_pkg::item_t   head_item,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ihe_pkg::out_t         m_data
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_TX_NRFD  = 3'd1;
    localparam logic [2:0] PH_TX_NDAC  = 3'd2;
    localparam logic [2:0] PH_RX_DAVLO = 3'd3;
    localparam logic [2:0] PH_RX_DAVHI = 3'd4;

    logic [7:0] timeout_limit_reg;
    logic [1:0] eos_mode_reg;

    logic [2:0] phase_reg, phase_next;
    logic       talker_reg, talker_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_eoi_reg, held_eoi_next;
    logic       held_atn_reg, held_atn_next;
    logic       eoi_only_reg, eoi_only_next;
    logic       prev_cr_reg, prev_cr_next;

    logic          m_valid_reg, m_valid_next;
    ihe_pkg::out_t m_data_reg, m_data_next;

    logic [7:0] count_ticked;
    logic       expired;
    logic [1:0] term;
    logic [1:0] status;
    logic       rx_done;
    logic       mend;

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_ticked = (head_item.tick && wait_count_reg != 8'hFF)
                        ? wait_count_reg + 8'd1 : wait_count_reg;
    assign expired = (timeout_limit_reg != ihe_pkg::WAIT_FOREVER)
                  && (count_ticked > timeout_limit_reg);
    assign term = eoi_only_reg ? ihe_pkg::EOS_EOI_ONLY : eos_mode_reg;

    always_comb begin
        phase_next      = phase_reg;
        talker_next     = talker_reg;
        wait_count_next = wait_count_reg;
        held_byte_next  = held_byte_reg;
        held_eoi_next   = held_eoi_reg;
        held_atn_next   = held_atn_reg;
        eoi_only_next   = eoi_only_reg;
        prev_cr_next    = prev_cr_reg;
        status          = ihe_pkg::ST_NONE;
        rx_done         = 1'b0;
        mend            = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (head_item.cmd_send) begin
                    talker_next     = 1'b1;
                    held_byte_next  = head_item.tx_byte;
                    held_eoi_next   = head_item.tx_eoi;
                    wait_count_next = '0;
                    phase_next      = PH_TX_NRFD;
                end else if (head_item.cmd_recv) begin
                    talker_next     = 1'b0;
                    held_eoi_next   = 1'b0;
                    eoi_only_next   = head_item.eoi_only;
                    wait_count_next = '0;
                    phase_next      = PH_RX_DAVLO;
                end
            end
            PH_TX_NRFD: begin
                if (head_item.nrfd_high) begin
                    phase_next      = PH_TX_NDAC;
                    wait_count_next = '0;
                end else begin
                    wait_count_next = count_ticked;
                end
            end
            PH_TX_NDAC: begin
                if (head_item.ndac_high) begin
                    phase_next    = PH_IDLE;
                    held_eoi_next = 1'b0;
                    status        = ihe_pkg::ST_DONE;
                end else begin
                    wait_count_next = count_ticked;
                end
            end
            PH_RX_DAVLO: begin
                if (!head_item.dav_high) begin
                    held_byte_next  = head_item.rx_byte;
                    held_eoi_next   = head_item.eoi_asserted;
                    held_atn_next   = head_item.atn_asserted;
                    phase_next      = PH_RX_DAVHI;
                    wait_count_next = '0;
                end else begin
                    wait_count_next = count_ticked;
                end
            end
            PH_RX_DAVHI: begin
                if (head_item.dav_high) begin
                    phase_next = PH_IDLE;
                    status     = ihe_pkg::ST_DONE;
                    rx_done    = 1'b1;
                    if (held_eoi_reg) begin
                        mend = 1'b1;
                    end else if (held_byte_reg == ihe_pkg::CHAR_CR) begin
                        mend = (term == ihe_pkg::EOS_CR);
                    end else if (held_byte_reg == ihe_pkg::CHAR_LF) begin
                        mend = (term == ihe_pkg::EOS_LF)
                            || (prev_cr_reg && term == ihe_pkg::EOS_CRLF);
                    end
                    prev_cr_next = mend ? 1'b0 : (held_byte_reg == ihe_pkg::CHAR_CR);
                end else begin
                    wait_count_next = count_ticked;
                end
            end
            default: begin
                talker_next   = 1'b0;
                phase_next    = PH_IDLE;
                held_eoi_next = 1'b0;
            end
        endcase

        // drop back to listener on an expired wait
        if (phase_reg != PH_IDLE && status == ihe_pkg::ST_NONE && expired
                && phase_next == phase_reg) begin
            talker_next   = 1'b0;
            phase_next    = PH_IDLE;
            held_eoi_next = 1'b0;
            prev_cr_next  = 1'b0;
            status        = ihe_pkg::ST_TIMEOUT;
        end
    end

    always_comb begin
        m_data_next.drive_data     = talker_next ? ~held_byte_next : ihe_pkg::DATA_FLOAT;
        m_data_next.drive_dav_low  = talker_next && (phase_next == PH_TX_NDAC);
        m_data_next.drive_eoi_low  = talker_next && held_eoi_next
                                  && (phase_next == PH_TX_NRFD || phase_next == PH_TX_NDAC);
        m_data_next.drive_nrfd_low = !talker_next && (phase_next != PH_RX_DAVLO);
        m_data_next.drive_ndac_low = !talker_next && (phase_next != PH_RX_DAVHI);
        m_data_next.talker_mode    = talker_next;
        m_data_next.busy_res       = (phase_next != PH_IDLE);
        m_data_next.status         = status;
        m_data_next.rx_byte        = rx_done ? held_byte_next : 8'd0;
        m_data_next.rx_eoi         = rx_done && held_eoi_next;
        m_data_next.rx_atn         = rx_done && held_atn_next;
        m_data_next.msg_end        = mend;

        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= ihe_pkg::TIMEOUT_RESET;
            eos_mode_reg      <= ihe_pkg::EOS_CRLF;
        end else if (cfg_wr.wr_en) begin
            case (cfg_wr.index)
                ihe_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wr.data;
                ihe_pkg::CFG_EOS_MODE:      eos_mode_reg      <= cfg_wr.data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            talker_reg     <= 1'b0;
            wait_count_reg <= '0;
            held_byte_reg  <= '0;
            held_eoi_reg   <= 1'b0;
            held_atn_reg   <= 1'b0;
            eoi_only_reg   <= 1'b0;
            prev_cr_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg      <= phase_next;
                talker_reg     <= talker_next;
                wait_count_reg <= wait_count_next;
                held_byte_reg  <= held_byte_next;
                held_eoi_reg   <= held_eoi_next;
                held_atn_reg   <= held_atn_next;
                eoi_only_reg   <= eoi_only_next;
                prev_cr_reg    <= prev_cr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ieee488_handshake_engine_unit.sv -----
// Top level of the IEEE-488 three-wire handshake engine: front, queue, back.
// Depends on ihe_pkg, ihe_front, ihe_queue and ihe_back.
// Path: a request is queued, then its result is registered in the back.
// Throughput: one request per cycle while m_valid is low or m_ready high.
// Reset: queue emptied, engine idle listener, timeout_limit 255, eos_mode 0.
`default_nettype none

module ieee488_handshake_engine_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ihe_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ihe_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);

    logic             queue_full;
    logic             push;
    ihe_pkg::item_t   push_item;
    logic             pop;
    logic             head_valid;
    ihe_pkg::item_t   head_item;
    ihe_pkg::cfg_wr_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.wr_en = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    ihe_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ihe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ihe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
